>>> rtl/core/csc_pkg.sv
// Package for the call schedule string check: character codes, parse phase codes,
// configuration register indexes, status structs and small helper functions.
// No dependencies.
package csc_pkg;

   localparam int CharW  = 8;
   localparam int ValW   = 12;
   localparam int PhaseW = 3;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 12;

   // Parse phases
   localparam logic [PhaseW-1:0] PH_PAIR_A    = 3'd0;
   localparam logic [PhaseW-1:0] PH_PAIR_B    = 3'd1;
   localparam logic [PhaseW-1:0] PH_SKIP      = 3'd2;
   localparam logic [PhaseW-1:0] PH_START     = 3'd3;
   localparam logic [PhaseW-1:0] PH_DASH_SEEN = 3'd4;
   localparam logic [PhaseW-1:0] PH_STOP      = 3'd5;
   localparam logic [PhaseW-1:0] PH_FAIL      = 3'd6;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_WEEK_DAY    = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_TIME_OF_DAY = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_FORCE_CALL  = 2'd2;

   localparam logic [CharW-1:0] CH_NUL   = 8'h00;
   localparam logic [CharW-1:0] CH_COMMA = 8'h2c;
   localparam logic [CharW-1:0] CH_DASH  = 8'h2d;
   localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
   localparam logic [CharW-1:0] CH_NINE  = 8'h39;
   localparam logic [CharW-1:0] CH_UC_A  = 8'h41;
   localparam logic [CharW-1:0] CH_LC_N  = 8'h6e;
   localparam logic [CharW-1:0] CH_LC_Y  = 8'h79;

   localparam logic [ValW-1:0] VAL_SAT   = 12'd4095;
   localparam logic [ValW-1:0] VAL_LIMIT = 12'd2400;

   localparam logic [2:0] NEVER_LEN = 3'd5;
   localparam logic [2:0] WK_INDEX  = 3'd7;

   // Two chars per day code; entry 7 is the weekday code
   localparam logic [16*CharW-1:0] DAY_CODES  = "SuMoTuWeThFrSaWk";
   localparam logic [5*CharW-1:0]  NEVER_WORD = "Never";

   typedef struct packed {
      logic step;    // feed one non-separator character
      logic clear;   // alternative ends, back to reset values
   } parse_ctl_type;

   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic              is_never;
      logic              day_found;
      logic [ValW-1:0]   range_start;
      logic [ValW-1:0]   range_stop;
   } parse_stat_type;

   function automatic logic is_digit(input logic [CharW-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [ValW-1:0] add_digit(input logic [ValW-1:0] v,
                                                 input logic [CharW-1:0] c);
      logic [15:0] n;
      n = 16'(v) * 16'd10 + 16'(c[3:0]);
      return (n > 16'(VAL_SAT)) ? VAL_SAT : n[ValW-1:0];
   endfunction

   function automatic logic [CharW-1:0] never_char(input logic [2:0] idx);
      logic [CharW-1:0] ch;
      case (idx)
         3'd0:    ch = NEVER_WORD[39:32];
         3'd1:    ch = NEVER_WORD[31:24];
         3'd2:    ch = NEVER_WORD[23:16];
         3'd3:    ch = NEVER_WORD[15:8];
         3'd4:    ch = NEVER_WORD[7:0];
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic day_pair_match(input logic [CharW-1:0] a,
                                           input logic [CharW-1:0] b,
                                           input logic [2:0]       wday);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (DAY_CODES[(15-2*i)*CharW +: CharW] == a &&
             DAY_CODES[(14-2*i)*CharW +: CharW] == b) begin
            if (3'(i) == wday ||
                (3'(i) == WK_INDEX && wday >= 3'd1 && wday <= 3'd5)) begin
               hit = 1'b1;
            end
         end
      end
      return hit;
   endfunction

endpackage

>>> rtl/core/csc_char_parse.sv
// Per-alternative character parser: day/Any pair scan, Never prefix, hhmm range.
// Depends on csc_pkg.
module csc_char_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  csc_pkg::parse_ctl_type      ctl,
   input  logic [csc_pkg::CharW-1:0]   char_code,
   input  logic [2:0]                  week_day,
   output csc_pkg::parse_stat_type     stat
);
   import csc_pkg::*;

   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [CharW-1:0]  first_ff, first_in;
   logic              any_ff, any_in;
   logic [2:0]        ncnt_ff, ncnt_in;
   logic              nbrk_ff, nbrk_in;
   logic              day_ff, day_in;
   logic [ValW-1:0]   start_ff, start_in;
   logic [ValW-1:0]   stop_ff, stop_in;

   always_comb begin
      phase_in = phase_ff;
      first_in = first_ff;
      any_in   = any_ff;
      ncnt_in  = ncnt_ff;
      nbrk_in  = nbrk_ff;
      day_in   = day_ff;
      start_in = start_ff;
      stop_in  = stop_ff;
      if (ctl.clear) begin
         phase_in = PH_PAIR_A;
         first_in = CH_NUL;
         any_in   = 1'b0;
         ncnt_in  = 3'd0;
         nbrk_in  = 1'b0;
         day_in   = 1'b0;
         start_in = '0;
         stop_in  = '0;
      end else if (ctl.step) begin
         if (!nbrk_ff && ncnt_ff < NEVER_LEN) begin
            if (char_code == never_char(ncnt_ff)) begin
               ncnt_in = ncnt_ff + 3'd1;
            end else begin
               nbrk_in = 1'b1;
            end
         end
         case (phase_ff)
            PH_PAIR_A: begin
               any_in = 1'b0;
               if (any_ff && char_code == CH_LC_Y) begin
                  day_in   = 1'b1;
                  phase_in = PH_SKIP;
               end else begin
                  first_in = char_code;
                  phase_in = PH_PAIR_B;
               end
            end
            PH_PAIR_B: begin
               if (first_ff == CH_UC_A && char_code == CH_LC_N) begin
                  any_in   = 1'b1;
                  phase_in = PH_PAIR_A;
               end else if (day_pair_match(first_ff, char_code, week_day)) begin
                  day_in   = 1'b1;
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_PAIR_A;
               end
            end
            PH_SKIP: begin
               if (is_digit(char_code)) begin
                  start_in = add_digit('0, char_code);
                  phase_in = PH_START;
               end
            end
            PH_START: begin
               if (is_digit(char_code)) begin
                  start_in = add_digit(start_ff, char_code);
               end else if (char_code == CH_DASH) begin
                  phase_in = PH_DASH_SEEN;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_DASH_SEEN, PH_STOP: begin
               if (is_digit(char_code)) begin
                  stop_in  = add_digit((phase_ff == PH_STOP) ? stop_ff : '0, char_code);
                  phase_in = PH_STOP;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PAIR_A;
         first_ff <= CH_NUL;
         any_ff   <= 1'b0;
         ncnt_ff  <= 3'd0;
         nbrk_ff  <= 1'b0;
         day_ff   <= 1'b0;
         start_ff <= '0;
         stop_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         any_ff   <= any_in;
         ncnt_ff  <= ncnt_in;
         nbrk_ff  <= nbrk_in;
         day_ff   <= day_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
      end
   end

   assign stat.phase       = phase_ff;
   assign stat.is_never    = (ncnt_ff == NEVER_LEN);
   assign stat.day_found   = day_ff;
   assign stat.range_start = start_ff;
   assign stat.range_stop  = stop_ff;

endmodule

>>> rtl/core/csc_alt_eval.sv
// Pass/fail of one finished alternative from parser status and time of day.
// Depends on csc_pkg.
module csc_alt_eval (
   input  csc_pkg::parse_stat_type    stat,
   input  logic [csc_pkg::ValW-1:0]   time_of_day,
   output logic                       alt_pass
);
   import csc_pkg::*;

   logic in_fwd, in_wrap;

   // forward range, and range that wraps past midnight
   assign in_fwd  = (stat.range_stop >= stat.range_start) &&
                    (time_of_day >= stat.range_start) && (time_of_day <= stat.range_stop);
   assign in_wrap = (stat.range_stop <= stat.range_start) &&
                    ((time_of_day >= stat.range_start) || (time_of_day <= stat.range_stop));

   always_comb begin
      if (stat.is_never || !stat.day_found) begin
         alt_pass = 1'b0;
      end else if (stat.phase == PH_SKIP) begin
         alt_pass = 1'b1;
      end else if (stat.phase != PH_STOP) begin
         alt_pass = 1'b0;
      end else if (stat.range_start > VAL_LIMIT || stat.range_stop > VAL_LIMIT) begin
         alt_pass = 1'b0;
      end else begin
         alt_pass = in_fwd || in_wrap;
      end
   end

endmodule

>>> rtl/core/call_schedule_string_check.sv
// Top level of the call schedule string check: input register, parser, verdict
// accumulation and result register. Depends on csc_pkg, csc_char_parse, csc_alt_eval.
//
// The block reads a schedule string one character per req beat and returns one
// rsp beat (call_allowed) for each zero character; commas split alternatives and
// the verdict is the OR of all of them (or, with force_call set, just whether the
// first alternative is not "Never"). Every character is one beat and the block
// takes one beat per cycle while req_stall is low: a character is registered in
// the input register, then the parser updates and, on a terminator, the verdict
// lands in the result register, which drives rsp_valid and the verdict beat.
// req_stall rises only when a zero character waits in the input register while
// the previous verdict is still held by rsp_stall; all other characters flow on.
// week_day, time_of_day and force_call are plain write registers and are to be
// written only between strings.
module call_schedule_string_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [csc_pkg::CharW-1:0]      req_char_code,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_call_allowed,
   input  logic                           csr_write,
   input  logic [csc_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [csc_pkg::CsrDataW-1:0]   csr_wdata
);
   import csc_pkg::*;

   // configuration
   logic [2:0]      week_day_ff;
   logic [ValW-1:0] time_of_day_ff;
   logic            force_call_ff;

   // input register
   logic             in_valid_ff;
   logic [CharW-1:0] in_char_ff;

   // verdict accumulation
   logic first_alt_ff, first_alt_in;
   logic verdict_ff, verdict_in;
   logic forced_ff, forced_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_allowed_ff, rsp_allowed_in;

   logic           is_nul, is_comma, advance, fire, fire_nul, fire_comma;
   logic           alt_pass, verdict_acc, forced_acc;
   parse_ctl_type  pctl;
   parse_stat_type pstat;

   always_ff @(posedge clock) begin
      if (reset) begin
         week_day_ff    <= 3'd0;
         time_of_day_ff <= '0;
         force_call_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WEEK_DAY:    week_day_ff    <= csr_wdata[2:0];
            CSR_TIME_OF_DAY: time_of_day_ff <= csr_wdata[ValW-1:0];
            CSR_FORCE_CALL:  force_call_ff  <= csr_wdata[0];
            default:         ; // unmapped index, dropped
         endcase
      end
   end

   assign is_nul   = (in_char_ff == CH_NUL);
   assign is_comma = (in_char_ff == CH_COMMA);

   // a terminator needs a free (or draining) result register
   assign advance    = !is_nul || !rsp_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && advance;
   assign fire_nul   = fire && is_nul;
   assign fire_comma = fire && is_comma;
   assign req_stall  = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_char_ff <= req_char_code;
      end
   end

   assign pctl.step  = fire && !is_nul && !is_comma;
   assign pctl.clear = fire_nul || fire_comma;

   csc_char_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pctl),
      .char_code (in_char_ff),
      .week_day  (week_day_ff),
      .stat      (pstat)
   );

   csc_alt_eval u_eval (
      .stat        (pstat),
      .time_of_day (time_of_day_ff),
      .alt_pass    (alt_pass)
   );

   assign verdict_acc = verdict_ff | alt_pass;
   assign forced_acc  = first_alt_ff ? !pstat.is_never : forced_ff;

   always_comb begin
      first_alt_in   = first_alt_ff;
      verdict_in     = verdict_ff;
      forced_in      = forced_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_allowed_in = rsp_allowed_ff;
      if (fire_comma) begin
         first_alt_in = 1'b0;
         verdict_in   = verdict_acc;
         forced_in    = forced_acc;
      end else if (fire_nul) begin
         first_alt_in   = 1'b1;
         verdict_in     = 1'b0;
         forced_in      = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_allowed_in = force_call_ff ? forced_acc : verdict_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_alt_ff <= 1'b1;
         verdict_ff   <= 1'b0;
         forced_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_alt_ff <= first_alt_in;
         verdict_ff   <= verdict_in;
         forced_ff    <= forced_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_allowed_ff <= rsp_allowed_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_call_allowed = rsp_allowed_ff;

`ifndef SYNTHESIS
   // only a blocked terminator may hold off the input
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && is_nul && rsp_valid_ff && rsp_stall))
      else $error("req_stall without a blocked terminator");

   // a terminator always produces a pending result beat
   a_nul_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      fire_nul |=> rsp_valid_ff)
      else $error("terminator did not load the result register");

   // after a terminator the accumulation state is back at reset values
   a_nul_clears: assert property (@(posedge clock) disable iff (reset)
      fire_nul |=> (first_alt_ff && !verdict_ff && !forced_ff))
      else $error("verdict state not cleared after terminator");

   // a comma leaves the first alternative
   a_comma_first: assert property (@(posedge clock) disable iff (reset)
      fire_comma |=> !first_alt_ff)
      else $error("first alternative flag still set after comma");

   // the parser is back at the pair scan after any separator
   a_sep_clears_parse: assert property (@(posedge clock) disable iff (reset)
      pctl.clear |=> (pstat.phase == PH_PAIR_A && !pstat.day_found))
      else $error("parser not cleared after separator");
`endif

endmodule

>>> tb/csc_verdict_checker.sv
// Verdict checker for the call schedule string check: mirrors the register writes,
// parses every accepted character and compares each rsp beat against the oldest verdict.
// Depends on csc_pkg for character codes, parse phases and register indexes.
module csc_verdict_checker
   import csc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [CharW-1:0]    req_char_code,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_call_allowed,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  fail_count,
   output int                  verdicts_owed
);

   // mirrored registers
   logic [2:0]      wday;
   logic [ValW-1:0] tod;
   logic            force_on;

   // parse state of the current alternative
   logic [PhaseW-1:0] phase;
   logic [CharW-1:0]  pair_first;
   logic              any_pend;
   logic [2:0]        nv_cnt;
   logic              nv_broken;
   logic              day_hit;
   logic [ValW-1:0]   start_val;
   logic [ValW-1:0]   stop_val;

   // per-string state
   logic first_alt;
   logic verdict_acc;
   logic forced_acc;

   logic verdict_due_q[$];

   function automatic logic is_num(input logic [CharW-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // decimal shift-in, clamps at the 12-bit ceiling
   function automatic logic [ValW-1:0] shift_in(input logic [ValW-1:0] v,
                                                input logic [CharW-1:0] c);
      int n;
      n = int'(v) * 10 + int'(c) - int'(CH_ZERO);
      return (n > int'(VAL_SAT)) ? VAL_SAT : ValW'(n);
   endfunction

   function automatic logic day_code_hit(input logic [CharW-1:0] a,
                                         input logic [CharW-1:0] b,
                                         input logic [2:0]       wd);
      int code;
      case ({a, b})
         "Su":    code = 0;
         "Mo":    code = 1;
         "Tu":    code = 2;
         "We":    code = 3;
         "Th":    code = 4;
         "Fr":    code = 5;
         "Sa":    code = 6;
         "Wk":    code = 7;
         default: code = -1;
      endcase
      if (code < 0) return 1'b0;
      return (code == int'(wd)) || (code == 7 && wd >= 3'd1 && wd <= 3'd5);
   endfunction

   function automatic logic alt_passes();
      if (nv_cnt == NEVER_LEN || !day_hit) return 1'b0;
      if (phase == PH_SKIP) return 1'b1;
      if (phase != PH_STOP) return 1'b0;
      if (start_val > VAL_LIMIT || stop_val > VAL_LIMIT) return 1'b0;
      if (stop_val >= start_val && tod >= start_val && tod <= stop_val) return 1'b1;
      // range wraps past midnight
      if (stop_val <= start_val && (tod >= start_val || tod <= stop_val)) return 1'b1;
      return 1'b0;
   endfunction

   task automatic restart_alt();
      phase      = PH_PAIR_A;
      pair_first = '0;
      any_pend   = 1'b0;
      nv_cnt     = '0;
      nv_broken  = 1'b0;
      day_hit    = 1'b0;
      start_val  = '0;
      stop_val   = '0;
   endtask

   task automatic parse_char(input logic [CharW-1:0] c);
      if (!nv_broken && nv_cnt < NEVER_LEN) begin
         if (c == NEVER_WORD[(4 - int'(nv_cnt)) * CharW +: CharW]) nv_cnt = nv_cnt + 3'd1;
         else nv_broken = 1'b1;
      end
      case (phase)
         PH_PAIR_A: begin
            if (any_pend && c == CH_LC_Y) begin
               day_hit = 1'b1;
               phase   = PH_SKIP;
            end else begin
               pair_first = c;
               phase      = PH_PAIR_B;
            end
            any_pend = 1'b0;
         end
         PH_PAIR_B: begin
            if (pair_first == CH_UC_A && c == CH_LC_N) begin
               any_pend = 1'b1;
               phase    = PH_PAIR_A;
            end else if (day_code_hit(pair_first, c, wday)) begin
               day_hit = 1'b1;
               phase   = PH_SKIP;
            end else begin
               phase = PH_PAIR_A;
            end
         end
         PH_SKIP: begin
            if (is_num(c)) begin
               start_val = shift_in('0, c);
               phase     = PH_START;
            end
         end
         PH_START: begin
            if (is_num(c)) start_val = shift_in(start_val, c);
            else if (c == CH_DASH) phase = PH_DASH_SEEN;
            else phase = PH_FAIL;
         end
         PH_DASH_SEEN, PH_STOP: begin
            if (is_num(c)) begin
               stop_val = shift_in((phase == PH_STOP) ? stop_val : '0, c);
               phase    = PH_STOP;
            end else begin
               phase = PH_FAIL;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      logic exp_v;
      if (reset) begin
         wday        = '0;
         tod         = '0;
         force_on    = 1'b0;
         restart_alt();
         first_alt   = 1'b1;
         verdict_acc = 1'b0;
         forced_acc  = 1'b0;
         verdict_due_q.delete();
         fail_count  = 0;
         verdicts_owed <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WEEK_DAY:    wday     = csr_wdata[2:0];
               CSR_TIME_OF_DAY: tod      = csr_wdata[ValW-1:0];
               CSR_FORCE_CALL:  force_on = csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (verdict_due_q.size() == 0) begin
               fail_count++;
               $display("%0t csc check: unexpected verdict, expected none, got %0b",
                        $time, rsp_call_allowed);
            end else begin
               exp_v = verdict_due_q.pop_front();
               if (rsp_call_allowed !== exp_v) begin
                  fail_count++;
                  $display("%0t csc check: call_allowed expected %0b, got %0b",
                           $time, exp_v, rsp_call_allowed);
               end
            end
         end

         if (req_valid && !req_stall) begin
            if (req_char_code != CH_NUL && req_char_code != CH_COMMA) begin
               parse_char(req_char_code);
            end else begin
               // end of an alternative: fold it in, register values taken now
               verdict_acc = verdict_acc | alt_passes();
               if (first_alt) forced_acc = (nv_cnt != NEVER_LEN);
               if (req_char_code == CH_COMMA) begin
                  first_alt = 1'b0;
               end else begin
                  verdict_due_q.push_back(force_on ? forced_acc : verdict_acc);
                  first_alt   = 1'b1;
                  verdict_acc = 1'b0;
                  forced_acc  = 1'b0;
               end
               restart_alt();
            end
         end

         verdicts_owed <= verdict_due_q.size();
      end
   end

endmodule

>>> tb/tb_top.sv
// Testbench top for the call schedule string check: clock, reset, schedule string
// stimulus, register programming, rsp back-pressure and the final verdict.
// Depends on csc_pkg, call_schedule_string_check and csc_verdict_checker.
module tb_top;
   import csc_pkg::*;

   // hard limit, far above the slowest legal run
   localparam int LIMIT_CYCLES = 250_000;
   localparam int RAND_CHARS   = 1000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CharW-1:0]    req_char_code;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_call_allowed;
   logic                csr_write;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   int fail_count;
   int verdicts_owed;

   // stimulus and rsp process state; rsp_hold_cycles is shared between them
   int   chars_sent;
   int   rsp_hold_cycles;   // one-shot long stall request for the rsp side
   logic tx_quiet;          // sender runs without gaps while set
   logic rx_quiet;          // receiver draws no stall stretch while set, bar a pending long hold
   logic [2:0] cur_wd;      // weekday currently programmed, biases the strings

   call_schedule_string_check u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_call_allowed (rsp_call_allowed),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   csc_verdict_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_call_allowed (rsp_call_allowed),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .verdicts_owed    (verdicts_owed)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Hard stop in case a handshake never completes.
   initial begin
      #(LIMIT_CYCLES * 8);
      $display("tb_top: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Schedule string generation
   // ------------------------------------------------------------------

   // A day-ish token. Four draws in fourteen name today (or Wk), so that plenty of
   // alternatives reach the range part; the rest are other codes, Any, a
   // dangling "An", random letter pairs, or a single letter that knocks the
   // pair alignment off by one.
   function automatic string day_token(input logic [2:0] wd);
      string codes;
      codes = "SuMoTuWeThFrSaWk";
      case ($urandom_range(0, 13))
         0, 1, 2: return codes.substr(2 * wd, 2 * wd + 1);
         3:       return "Wk";
         4:       return "Any";
         5:       return "An";
         6, 7, 8: return codes.substr(2 * $urandom_range(0, 7), 2 * $urandom_range(0, 7) + 1);
         9, 10:   return $sformatf("%c%c", $urandom_range(65, 122), $urandom_range(65, 122));
         11:      return $sformatf("%c", $urandom_range(65, 122));
         default: begin
            int k;
            k = $urandom_range(0, 7);
            return codes.substr(2 * k, 2 * k + 1);
         end
      endcase
   endfunction

   // One end of an hhmm range: mostly clock times, plus the 2400 limit, values
   // past it up to 9999, and runs of 1 to 7 digits that can run into saturation.
   function automatic string range_value();
      string v;
      int n;
      case ($urandom_range(0, 9))
         0: begin
            v = "";
            n = $urandom_range(1, 7);
            for (int i = 0; i < n; i++) v = {v, $sformatf("%0d", $urandom_range(0, 9))};
            return v;
         end
         1:       return $sformatf("%0d", $urandom_range(2401, 9999));
         2:       return "2400";
         default: return $sformatf("%02d%02d", $urandom_range(0, 23), $urandom_range(0, 59));
      endcase
   endfunction

   function automatic string random_noise();
      string v;
      int n;
      v = "";
      n = $urandom_range(1, 8);
      // bytes 1..255; comma may slip in and split the alternative
      for (int i = 0; i < n; i++) v = {v, $sformatf("%c", $urandom_range(1, 255))};
      return v;
   endfunction

   function automatic string random_schedule(input logic [2:0] wd);
      string s, alt;
      int n_alt, kind, n_tok, r;
      s = "";
      n_alt = $urandom_range(1, 3);
      for (int a = 0; a < n_alt; a++) begin
         alt  = "";
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            alt = ($urandom_range(0, 1) == 1) ? "Never" : {"Never", day_token(wd)};
         end else if (kind < 13) begin
            // prefixes and near misses of Never that must not count as Never
            case ($urandom_range(0, 2))
               0:       alt = {"Neve", day_token(wd)};
               1:       alt = {"Nev", day_token(wd)};
               default: alt = {"Neveq", day_token(wd)};
            endcase
         end else if (kind < 17) begin
            alt = "";
         end else if (kind < 23) begin
            alt = random_noise();
         end else begin
            n_tok = $urandom_range(1, 3);
            for (int t = 0; t < n_tok; t++) alt = {alt, day_token(wd)};
            if ($urandom_range(0, 4) == 0) alt = {alt, ($urandom_range(0, 1) == 1) ? " " : "/x"};
            r = $urandom_range(0, 99);
            if (r < 55)      alt = {alt, range_value(), "-", range_value()};
            else if (r < 62) alt = {alt, range_value()};
            else if (r < 68) alt = {alt, range_value(), "-"};
            else if (r < 74) alt = {alt, range_value(), "-", range_value(), "z"};
            else if (r < 78) alt = {alt, range_value(), "--", range_value()};
            else if (r < 82) alt = {alt, "-", range_value()};
            // otherwise no range at all
         end
         s = (a == 0) ? alt : {s, ",", alt};
      end
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // One req beat. Draws its own lead gap, then holds valid and the character
   // until the beat is taken. Leaves valid high so back-to-back beats have no
   // bubble; the caller lowers it when the stream pauses.
   task automatic send_char(input logic [CharW-1:0] c);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      chars_sent++;
   endtask

   // A whole schedule string followed by its zero terminator.
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(CH_NUL);
   endtask

   // Registers only move while the block is idle: stop the stream, wait for
   // every owed verdict, then write all three registers on consecutive cycles
   // with the write strobe held high.
   task automatic program_regs(input logic [2:0] wd, input logic [ValW-1:0] tod,
                               input logic frc);
      req_valid <= 1'b0;
      wait (verdicts_owed == 0);
      repeat (4) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_WEEK_DAY;
      csr_wdata <= CsrDataW'(wd);
      @(negedge clock);
      csr_index <= CSR_TIME_OF_DAY;
      csr_wdata <= CsrDataW'(tod);
      @(negedge clock);
      csr_index <= CSR_FORCE_CALL;
      csr_wdata <= CsrDataW'(frc);
      @(negedge clock);
      csr_write <= 1'b0;
      cur_wd = wd;
   endtask

   // rsp side: per beat, draw a stall stretch, then stay open until a beat is
   // taken. A pending long hold replaces the draw once.
   initial begin
      int gap;
      rsp_stall = 1'b0;
      rx_quiet  = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = rx_quiet ? 0 : $urandom_range(0, 14);
         end
         if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int   rand_start;
      int   strings_left;
      logic hold_done;
      logic [2:0]      wd;
      logic [ValW-1:0] tod;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_char_code   = '0;
      csr_write       = 1'b0;
      csr_index       = CSR_WEEK_DAY;
      csr_wdata       = '0;
      chars_sent      = 0;
      rsp_hold_cycles = 0;
      tx_quiet        = 1'b0;
      cur_wd          = '0;
      hold_done       = 1'b0;
      strings_left    = 0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed: Monday at midnight, schedule honored.
      program_regs(3'd1, 12'd0, 1'b0);
      send_text("");              // empty string: nothing passes
      send_text("Any");
      send_text("Mo");
      send_text("Never,Any");     // Never fails, Any still passes
      send_text("Neve,Tu");       // short prefix is an ordinary alternative
      send_text("Mo2300-0100");   // wraps past midnight, time 0 inside
      send_text("Mo12345-2400");  // long digit run saturates and fails
      send_text("TuM");           // odd leftover character at the end of the scan
      send_text("Wk0000-0000");

      // Directed: weekday seven, time past the legal range, forced calling.
      program_regs(3'd7, 12'd4095, 1'b1);
      send_text("Never,Any");     // leading Never wins even when forced
      send_text(",Never");        // empty first alternative is not Never
      send_text("Wk\377");
      send_text("Su");

      // Directed: Saturday, last minute of the day, back to the schedule.
      program_regs(3'd6, 12'd2359, 1'b0);
      send_text("Sa2359-2400");
      send_text("Fr,Sa0000-2358");
      send_text("Wk,Sa-");

      // Random schedules, re-programming the registers every few strings.
      rand_start = chars_sent;
      while (chars_sent - rand_start < RAND_CHARS) begin
         if (strings_left == 0) begin
            wd  = 3'($urandom_range(0, 7));
            tod = ($urandom_range(0, 4) == 0) ? ValW'($urandom_range(0, 4095))
                                              : ValW'($urandom_range(0, 2359));
            program_regs(wd, tod, ($urandom_range(0, 3) == 0));
            strings_left = $urandom_range(4, 20);
         end
         if ($urandom_range(0, 4) == 0) tx_quiet = !tx_quiet;
         // Once, hold rsp off for a long time while req keeps streaming, so the
         // result register fills and req_stall has to rise. Enough strings stay
         // queued that no register write pauses the stream during the hold.
         if (!hold_done && chars_sent - rand_start >= RAND_CHARS / 3) begin
            rsp_hold_cycles = $urandom_range(250, 400);
            tx_quiet        = 1'b1;
            hold_done       = 1'b1;
            if (strings_left < 8) strings_left = 8;
         end
         send_text(random_schedule(cur_wd));
         strings_left--;
      end

      req_valid <= 1'b0;
      wait (verdicts_owed == 0);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
